// File: rtl/bbc_pkg.sv
// Package for the bracket balance checker: sizes, operation codes and the
// queue item type. Used by every module of the block; depends on nothing.
`default_nettype none
package bbc_pkg;

  // Stack sizing
  localparam int STACK_DEPTH = 64;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int LVL_W       = $clog2(STACK_DEPTH + 1);
  localparam int OPEN_W      = 7;

  // Front-to-back queue sizing
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  // Bracket kinds
  localparam logic [1:0] KIND_ROUND  = 2'd0;
  localparam logic [1:0] KIND_SQUARE = 2'd1;
  localparam logic [1:0] KIND_CURLY  = 2'd2;

  // Stack operations
  localparam logic [1:0] OP_NONE = 2'd0;
  localparam logic [1:0] OP_PUSH = 2'd1;
  localparam logic [1:0] OP_POP  = 2'd2;

  // Character codes
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  // Classified character as it travels through the queue
  typedef struct packed {
    logic [1:0] op;
    logic [1:0] kind;
    logic       last;
  } item_t;

endpackage
`default_nettype wire

// File: rtl/bbc_front.sv
// Front end: accepts input transactions and classifies each byte into a
// stack operation. Depends on bbc_pkg.
`default_nettype none
module bbc_front import bbc_pkg::*; (
  input  wire logic [7:0] in_tdata,   // [7:0] char_code
  input  wire logic       in_tlast,   // is_final
  input  wire logic       in_tvalid,
  output logic            in_tready,
  output logic            q_valid,
  input  wire logic       q_ready,
  output item_t           q_item
);

  // Handshake straight through to the queue
  assign in_tready = q_ready;
  assign q_valid   = in_tvalid;

  // Byte classification
  always_comb begin
    q_item.last = in_tlast;
    q_item.op   = OP_NONE;
    q_item.kind = KIND_ROUND;
    case (in_tdata)
      CH_LPAREN: begin q_item.op = OP_PUSH; q_item.kind = KIND_ROUND;  end
      CH_LBRACK: begin q_item.op = OP_PUSH; q_item.kind = KIND_SQUARE; end
      CH_LBRACE: begin q_item.op = OP_PUSH; q_item.kind = KIND_CURLY;  end
      CH_RPAREN: begin q_item.op = OP_POP;  q_item.kind = KIND_ROUND;  end
      CH_RBRACK: begin q_item.op = OP_POP;  q_item.kind = KIND_SQUARE; end
      CH_RBRACE: begin q_item.op = OP_POP;  q_item.kind = KIND_CURLY;  end
      default: begin
        q_item.op   = OP_NONE;
        q_item.kind = KIND_ROUND;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/bbc_queue.sv
// Short FIFO between front and back so each side can stall on its own.
// Depends on bbc_pkg.
`default_nettype none
module bbc_queue import bbc_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  wr_valid,
  output logic       wr_ready,
  input  wire item_t wr_item,
  output logic       rd_valid,
  input  wire logic  rd_ready,
  output item_t      rd_item
);

  item_t              entry_r [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  count_r, count_nxt;
  logic               do_wr, do_rd;

  assign wr_ready = (count_r != QCNT_W'(QDEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_item  = entry_r[rd_ptr_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk) begin
    if (do_wr) begin
      entry_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule
`default_nettype wire

// File: rtl/bbc_back.sv
// Back end: bracket stack, sticky error flags and the result register.
// Top of stack lives in a register; entries below it sit in a memory whose
// registered read always prefetches the entry under the top. Depends on bbc_pkg.
`default_nettype none
module bbc_back import bbc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        q_valid,
  output logic             q_ready,
  input  wire item_t       q_item,
  output logic [15:0]      out_tdata,  // [0] balanced, [1] overflowed, [8:2] open_left
  output logic             out_tvalid,
  input  wire logic        out_tready
);

  logic [1:0]        stack_mem [STACK_DEPTH];
  logic [1:0]        rd_q_r;
  logic              byp_r;
  logic [1:0]        byp_data_r;
  logic [1:0]        below;

  logic [LVL_W-1:0]  level_r, level_nxt, level_upd;
  logic [1:0]        tos_r, tos_nxt;
  logic              mis_r, mis_nxt, mis_upd;
  logic              ovf_r, ovf_nxt, ovf_upd;
  logic              frozen, take, full, empty;
  logic              we;
  logic [ADDR_W-1:0] wr_addr, rd_addr;

  logic              out_valid_r, out_valid_nxt;
  logic              res_bal_r;
  logic              res_ovf_r;
  logic [OPEN_W-1:0] res_open_r;

  // Accept a final item only when the result slot frees up
  assign q_ready = !q_item.last || !out_valid_r || out_tready;
  assign take    = q_valid && q_ready;
  assign frozen  = mis_r || ovf_r;
  assign full    = (level_r == LVL_W'(STACK_DEPTH));
  assign empty   = (level_r == '0);
  assign below   = byp_r ? byp_data_r : rd_q_r;

  // Stack step
  always_comb begin
    level_upd = level_r;
    tos_nxt   = tos_r;
    mis_upd   = mis_r;
    ovf_upd   = ovf_r;
    we        = 1'b0;
    wr_addr   = ADDR_W'(level_r - 1'b1);
    if (take && !frozen) begin
      case (q_item.op)
        OP_PUSH: begin
          if (full) begin
            ovf_upd = 1'b1;
          end else begin
            we        = !empty;
            tos_nxt   = q_item.kind;
            level_upd = level_r + 1'b1;
          end
        end
        OP_POP: begin
          if (empty || (tos_r != q_item.kind)) begin
            mis_upd = 1'b1;
          end else begin
            tos_nxt   = below;
            level_upd = level_r - 1'b1;
          end
        end
        default: begin
          level_upd = level_r;
        end
      endcase
    end
  end

  // Clear for the next string after a final item
  always_comb begin
    level_nxt = level_upd;
    mis_nxt   = mis_upd;
    ovf_nxt   = ovf_upd;
    if (take && q_item.last) begin
      level_nxt = '0;
      mis_nxt   = 1'b0;
      ovf_nxt   = 1'b0;
    end
  end

  // Prefetch the entry under the next top
  assign rd_addr = ADDR_W'(level_nxt - LVL_W'(2));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= '0;
      mis_r   <= 1'b0;
      ovf_r   <= 1'b0;
      byp_r   <= 1'b0;
    end else begin
      level_r <= level_nxt;
      mis_r   <= mis_nxt;
      ovf_r   <= ovf_nxt;
      byp_r   <= we;
    end
  end

  // Stack memory and top-of-stack payload
  always_ff @(posedge clk) begin
    if (we) begin
      stack_mem[wr_addr] <= tos_r;
    end
    rd_q_r     <= stack_mem[rd_addr];
    byp_data_r <= tos_r;
    tos_r      <= tos_nxt;
  end

  // Result register
  assign out_valid_nxt = (take && q_item.last) ? 1'b1 :
                         (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && q_item.last) begin
      res_bal_r  <= !mis_upd && !ovf_upd && (level_upd == '0);
      res_ovf_r  <= ovf_upd;
      res_open_r <= OPEN_W'(level_upd);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(16 - 2 - OPEN_W){1'b0}}, res_open_r, res_ovf_r, res_bal_r};

endmodule
`default_nettype wire

// File: rtl/bracket_balance_checker_unit.sv
// Bracket balance checker, top level: front classifier, queue, stack back end.
// Result: the final byte passes through the queue, and the back end takes it
// into the result register, which holds it until out_tready is high.
// Throughput: one byte per cycle while the result slot is free, set by the single
// stack step per cycle with the top of stack in a register and a memory prefetch.
// Reset: synchronous, active low; clears queue, level, flags and result valid.
// No clearing pass; stack memory is not reset.
`default_nettype none
module bracket_balance_checker_unit import bbc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [7:0]  in_tdata,   // [7:0] char_code
  input  wire logic        in_tlast,   // is_final
  input  wire logic        in_tvalid,
  output logic             in_tready,
  output logic [15:0]      out_tdata,  // [0] balanced, [1] overflowed, [8:2] open_left
  output logic             out_tvalid,
  input  wire logic        out_tready
);

  logic  fq_valid, fq_ready;
  item_t fq_item;
  logic  qb_valid, qb_ready;
  item_t qb_item;

  bbc_front u_front (
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .q_valid   (fq_valid),
    .q_ready   (fq_ready),
    .q_item    (fq_item)
  );

  bbc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_item  (fq_item),
    .rd_valid (qb_valid),
    .rd_ready (qb_ready),
    .rd_item  (qb_item)
  );

  bbc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (qb_valid),
    .q_ready    (qb_ready),
    .q_item     (qb_item),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready)
  );

endmodule
`default_nettype wire
